### sv/gsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gsf_pkg;

   localparam int GroupBytes  = 5;
   localparam int GroupBits   = 40;
   localparam int NibLanes    = 8;
   localparam int GapWidth    = 5;
   localparam int CountWidth  = 5;
   localparam int GroupsWidth = 7;
   localparam int CsrIdxWidth = 2;

   localparam logic [7:0] SyncByte   = 8'hFF;
   localparam logic [7:0] GapByte    = 8'h55;
   localparam logic [7:0] HdrMark    = 8'h08;
   localparam logic [7:0] HdrPad     = 8'h0F;
   localparam logic [7:0] ErrByte    = 8'h00;

   localparam logic [CsrIdxWidth-1:0] RegHeaderGap = 2'd0;
   localparam logic [CsrIdxWidth-1:0] RegTailGap   = 2'd1;

   function automatic logic [4:0] nib_code(input logic [3:0] nib);
      case (nib)
         4'h0:    return 5'h0a;
         4'h1:    return 5'h0b;
         4'h2:    return 5'h12;
         4'h3:    return 5'h13;
         4'h4:    return 5'h0e;
         4'h5:    return 5'h0f;
         4'h6:    return 5'h16;
         4'h7:    return 5'h17;
         4'h8:    return 5'h09;
         4'h9:    return 5'h19;
         4'ha:    return 5'h1a;
         4'hb:    return 5'h1b;
         4'hc:    return 5'h0d;
         4'hd:    return 5'h1d;
         4'he:    return 5'h1e;
         default: return 5'h15;
      endcase
   endfunction

   typedef enum logic [1:0] {
      KIND_HDR  = 2'd0,
      KIND_DATA = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SYNC1 = 9'b000000010,
      ST_GRP1  = 9'b000000100,
      ST_GRP2  = 9'b000001000,
      ST_HGAP  = 9'b000010000,
      ST_SYNC2 = 9'b000100000,
      ST_DGRP  = 9'b001000000,
      ST_TGAP  = 9'b010000000,
      ST_ERR   = 9'b100000000
   } seq_state_type;

   typedef struct packed {
      kind_type              kind;
      logic                  last;
      logic [31:0]           word_a;
      logic [15:0]           ids;
      logic [GapWidth-1:0]   hgap;
      logic [GapWidth-1:0]   tgap;
   } job_type;

   typedef struct packed {
      logic run_last;
      logic sector_end;
      logic seq_error;
   } flags_type;

endpackage

`default_nettype wire

### sv/gsf_nib_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module gsf_nib_lane (
   input  wire logic [3:0] nibble,
   output logic      [4:0] code
);
   import gsf_pkg::*;

   assign code = nib_code(nibble);

endmodule

`default_nettype wire

### sv/gsf_gcr_lanes.sv
`timescale 1ns / 1ps
`default_nettype none

module gsf_gcr_lanes (
   input  wire logic [31:0] word,
   output logic      [39:0] gcr
);
   import gsf_pkg::*;

   logic [4:0] code [NibLanes];

   for (genvar i = 0; i < NibLanes; i++) begin : g_lane
      gsf_nib_lane u_lane (
         .nibble (word[31-4*i -: 4]),
         .code   (code[i])
      );
   end

   // merge: first nibble's code in the top bits
   always_comb begin
      for (int i = 0; i < NibLanes; i++) begin
         gcr[GroupBits-1-5*i -: 5] = code[i];
      end
   end

endmodule

`default_nettype wire

### sv/gsf_byte_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module gsf_byte_seq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               job_valid,
   input  wire gsf_pkg::job_type   job,
   output logic                    job_take,
   input  wire logic               rsp_tready,
   output logic                    rsp_tvalid,
   output logic [7:0]              rsp_byte,
   output gsf_pkg::flags_type      rsp_flags
);
   import gsf_pkg::*;

   seq_state_type          state_ff, state_in;
   logic [CountWidth-1:0]  cnt_ff, cnt_in;
   logic [GroupBits-1:0]   shreg_ff, shreg_in;
   logic [15:0]            ids_ff, ids_in;
   logic                   last_ff, last_in;
   logic [GapWidth-1:0]    hgap_ff, hgap_in;
   logic [GapWidth-1:0]    tgap_ff, tgap_in;
   logic                   valid_ff, valid_in;
   logic [7:0]             byte_ff, byte_in;
   flags_type              flags_ff, flags_in;

   logic                   adv;
   logic                   fin;
   logic [7:0]             cur_byte;
   flags_type              cur_flags;
   logic [31:0]            enc_word;
   logic [GroupBits-1:0]   enc_gcr;
   seq_state_type          step_state;
   logic [CountWidth-1:0]  step_cnt;
   logic [GroupBits-1:0]   step_shreg;

   assign adv      = (state_ff != ST_IDLE) && (!valid_ff || rsp_tready);
   assign job_take = job_valid && ((state_ff == ST_IDLE) || (adv && fin));
   assign enc_word = job_take ? job.word_a : {ids_ff, HdrPad, HdrPad};

   gsf_gcr_lanes u_lanes (
      .word (enc_word),
      .gcr  (enc_gcr)
   );

   always_comb begin
      step_state = state_ff;
      step_cnt   = cnt_ff - CountWidth'(1);
      step_shreg = shreg_ff;
      cur_byte   = ErrByte;
      cur_flags  = '0;
      fin        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            step_cnt = cnt_ff;
         end
         ST_SYNC1: begin
            cur_byte = SyncByte;
            if (cnt_ff == '0) begin
               step_state = ST_GRP1;
               step_cnt   = CountWidth'(GroupBytes - 1);
            end
         end
         ST_GRP1: begin
            cur_byte   = shreg_ff[GroupBits-1 -: 8];
            step_shreg = {shreg_ff[GroupBits-9:0], 8'h00};
            if (cnt_ff == '0) begin
               step_state = ST_GRP2;
               step_cnt   = CountWidth'(GroupBytes - 1);
               step_shreg = enc_gcr;
            end
         end
         ST_GRP2: begin
            cur_byte   = shreg_ff[GroupBits-1 -: 8];
            step_shreg = {shreg_ff[GroupBits-9:0], 8'h00};
            if (cnt_ff == '0) begin
               if (hgap_ff == '0) begin
                  step_state = ST_SYNC2;
                  step_cnt   = CountWidth'(GroupBytes - 1);
               end else begin
                  step_state = ST_HGAP;
                  step_cnt   = CountWidth'(hgap_ff - GapWidth'(1));
               end
            end
         end
         ST_HGAP: begin
            cur_byte = GapByte;
            if (cnt_ff == '0) begin
               step_state = ST_SYNC2;
               step_cnt   = CountWidth'(GroupBytes - 1);
            end
         end
         ST_SYNC2: begin
            cur_byte = SyncByte;
            if (cnt_ff == '0) begin
               fin                = 1'b1;
               cur_flags.run_last = 1'b1;
            end
         end
         ST_DGRP: begin
            cur_byte   = shreg_ff[GroupBits-1 -: 8];
            step_shreg = {shreg_ff[GroupBits-9:0], 8'h00};
            if (cnt_ff == '0) begin
               if (last_ff && (tgap_ff != '0)) begin
                  step_state = ST_TGAP;
                  step_cnt   = CountWidth'(tgap_ff - GapWidth'(1));
               end else begin
                  fin                  = 1'b1;
                  cur_flags.run_last   = 1'b1;
                  cur_flags.sector_end = last_ff;
               end
            end
         end
         ST_TGAP: begin
            cur_byte = GapByte;
            if (cnt_ff == '0) begin
               fin                  = 1'b1;
               cur_flags.run_last   = 1'b1;
               cur_flags.sector_end = 1'b1;
            end
         end
         ST_ERR: begin
            fin                 = 1'b1;
            cur_flags.run_last  = 1'b1;
            cur_flags.seq_error = 1'b1;
         end
         default: begin
            step_state = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      shreg_in = shreg_ff;
      ids_in   = ids_ff;
      last_in  = last_ff;
      hgap_in  = hgap_ff;
      tgap_in  = tgap_ff;
      if (adv) begin
         state_in = fin ? ST_IDLE : step_state;
         cnt_in   = step_cnt;
         shreg_in = step_shreg;
      end
      if (job_take) begin
         cnt_in   = CountWidth'(GroupBytes - 1);
         shreg_in = enc_gcr;
         ids_in   = job.ids;
         last_in  = job.last;
         hgap_in  = job.hgap;
         tgap_in  = job.tgap;
         unique case (job.kind)
            KIND_HDR:  state_in = ST_SYNC1;
            KIND_DATA: state_in = ST_DGRP;
            default:   state_in = ST_ERR;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      flags_in = flags_ff;
      if (adv) begin
         valid_in = 1'b1;
         byte_in  = cur_byte;
         flags_in = cur_flags;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      cnt_ff   <= cnt_in;
      shreg_ff <= shreg_in;
      ids_ff   <= ids_in;
      last_ff  <= last_in;
      hgap_ff  <= hgap_in;
      tgap_ff  <= tgap_in;
      byte_ff  <= byte_in;
      flags_ff <= flags_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_byte   = byte_ff;
   assign rsp_flags  = flags_ff;

   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      valid_ff && flags_ff.seq_error |-> flags_ff.run_last && (byte_ff == ErrByte)
                                        && !flags_ff.sector_end)
      else $error("error item not a lone zero byte");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && flags_ff.sector_end |-> flags_ff.run_last)
      else $error("sector end without run end");

   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      job_take |-> job_valid)
      else $error("job taken from empty slot");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && !job_valid |=> !$rose(valid_ff))
      else $error("byte emitted while idle");

endmodule

`default_nettype wire

### sv/gcr_sector_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake             Payload
// req_     in   req_tvalid/tready     tdata: data_word, track, sector, id1, id2; tuser: type
// rsp_     out  rsp_tvalid/tready     tdata: gcr byte; tlast: run end; tuser: flags
// csr_     in   csr_valid/csr_ready   csr_index, csr_data (gap lengths)
//
// One output byte per cycle while rsp_tready is high and an item is running. A data item
// gives 5 bytes, or 5 + tail gap for the last group; a header gives 20 + header gap; an
// out-of-sector data item gives one zero byte, and output pauses after it as the slot refills.
// The byte sequencer sets the rate; one item waits in the input slot meanwhile.
// Reset is synchronous and clears the sector state; gaps return to 9 and 6.
// A stalled rsp_tready holds the output register and the sequencer behind it.

module gcr_sector_framer #(
   parameter int DATA_GROUPS = 65
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [31:0] data_word, [39:32] track_num, [47:40] sector_num,
   // [55:48] disk_id_first, [63:56] disk_id_second
   input  wire logic [63:0] req_tdata,
   // [0] req_type
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] gcr_byte
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   // [0] sector_end, [1] seq_error
   output logic [1:0]       rsp_tuser,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [4:0]  csr_data
);
   import gsf_pkg::*;

   logic [GapWidth-1:0]    hgap_ff, hgap_in;
   logic [GapWidth-1:0]    tgap_ff, tgap_in;
   logic [GroupsWidth-1:0] groups_ff, groups_in;
   logic                   in_sector_ff, in_sector_in;
   logic                   job_valid_ff, job_valid_in;
   job_type                job_ff, job_in;

   logic                   accept;
   logic                   job_take;
   logic [7:0]             trk, sec, id1, id2;
   logic [GroupsWidth-1:0] groups_dec;
   flags_type              flags;

   assign csr_ready  = 1'b1;
   assign req_tready = !job_valid_ff;
   assign accept     = req_tvalid && req_tready;

   assign trk        = req_tdata[39:32];
   assign sec        = req_tdata[47:40];
   assign id1        = req_tdata[55:48];
   assign id2        = req_tdata[63:56];
   assign groups_dec = groups_ff - GroupsWidth'(1);

   always_comb begin
      hgap_in = hgap_ff;
      tgap_in = tgap_ff;
      if (csr_valid) begin
         unique case (csr_index)
            RegHeaderGap: hgap_in = csr_data;
            RegTailGap:   tgap_in = csr_data;
            default:      ;
         endcase
      end
   end

   // decode the item against the sector state as it is accepted
   always_comb begin
      groups_in    = groups_ff;
      in_sector_in = in_sector_ff;
      job_valid_in = job_valid_ff && !job_take;
      job_in       = job_ff;
      if (accept) begin
         job_valid_in = 1'b1;
         job_in.hgap  = hgap_ff;
         job_in.tgap  = tgap_ff;
         job_in.ids   = {id2, id1};
         job_in.last  = 1'b0;
         if (req_tuser[0] == 1'b0) begin
            job_in.kind   = KIND_HDR;
            job_in.word_a = {HdrMark, sec ^ trk ^ id2 ^ id1, sec, trk};
            groups_in     = GroupsWidth'(DATA_GROUPS);
            in_sector_in  = 1'b1;
         end else if (!in_sector_ff) begin
            job_in.kind   = KIND_ERR;
            job_in.word_a = req_tdata[31:0];
         end else begin
            job_in.kind   = KIND_DATA;
            job_in.word_a = req_tdata[31:0];
            job_in.last   = (groups_dec == '0);
            groups_in     = groups_dec;
            in_sector_in  = (groups_dec != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hgap_ff      <= GapWidth'(9);
         tgap_ff      <= GapWidth'(6);
         groups_ff    <= '0;
         in_sector_ff <= 1'b0;
         job_valid_ff <= 1'b0;
      end else begin
         hgap_ff      <= hgap_in;
         tgap_ff      <= tgap_in;
         groups_ff    <= groups_in;
         in_sector_ff <= in_sector_in;
         job_valid_ff <= job_valid_in;
      end
      job_ff <= job_in;
   end

   gsf_byte_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid_ff),
      .job        (job_ff),
      .job_take   (job_take),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_byte   (rsp_tdata),
      .rsp_flags  (flags)
   );

   assign rsp_tlast = flags.run_last;
   assign rsp_tuser = {flags.seq_error, flags.sector_end};

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && !job_take |=> job_valid_ff && $stable(job_ff))
      else $error("pending item lost");

   a_sector_groups: assert property (@(posedge clock) disable iff (reset)
      !in_sector_ff |-> !accept || req_tuser[0] == 1'b0 || job_in.kind == KIND_ERR)
      else $error("data accepted outside a sector");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      accept && job_in.last |=> !in_sector_ff)
      else $error("last group left sector open");

endmodule

`default_nettype wire
